### design/bqs_pkg.sv
package bqs_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 18;
    localparam int MCOEF_W  = COEF_W + 1;
    localparam int PROD_W   = 43;
    localparam int ACC_W    = 46;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;
    localparam int BPK_W    = 3 * COEF_W;
    localparam int APK_W    = 2 * COEF_W;

    typedef enum logic [2:0] {
        REG_FILTER_ENABLE = 3'd0,
        REG_COUPLING_MODE = 3'd1,
        REG_CPL_B         = 3'd2,
        REG_CPL_A         = 3'd3,
        REG_LP_B          = 3'd4,
        REG_LP_A          = 3'd5,
        REG_HP_B          = 3'd6,
        REG_HP_A          = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        STG_CPL = 2'd0,
        STG_LP  = 2'd1,
        STG_HP  = 2'd2
    } stage_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_OUT  = 2'd2
    } state_t;

    typedef enum logic [2:0] {
        TAP_B0      = 3'd0,
        TAP_B1      = 3'd1,
        TAP_B2      = 3'd2,
        TAP_A1      = 3'd3,
        TAP_A2      = 3'd4,
        TAP_DRAIN   = 3'd5,
        TAP_CAPTURE = 3'd6
    } tap_t;

    // Index 0 is the coupling stage, 1 lowpass, 2 highpass.
    typedef struct packed {
        logic                  filter_enable;
        logic                  coupling_mode;
        logic [2:0][BPK_W-1:0] b_coefs;
        logic [2:0][APK_W-1:0] a_coefs;
    } cfg_t;

    typedef struct packed {
        logic                      valid;
        logic                      first;
        logic signed [MCOEF_W-1:0] coef;
        logic signed [SAMPLE_W-1:0] data;
    } mac_op_t;

    function automatic logic signed [MCOEF_W-1:0] coef_b(
        input logic [BPK_W-1:0] w,
        input logic [1:0]       k
    );
        logic [COEF_W-1:0] c;
        c = w[COEF_W*k +: COEF_W];
        return {c[COEF_W-1], c};
    endfunction

    // Feedback coefficients are negated so the unit only ever adds.
    function automatic logic signed [MCOEF_W-1:0] coef_a_neg(
        input logic [APK_W-1:0] w,
        input logic             k
    );
        logic [COEF_W-1:0] c;
        c = w[COEF_W*k +: COEF_W];
        return -$signed({c[COEF_W-1], c});
    endfunction

endpackage

### design/biquad_lowpass_highpass_split.sv
// Two-way crossover: each request carries one signed Q1.23 sample; the result
// carries the lowpass and highpass outputs, each rounded and saturated to 24 bits.
// All products (fifteen with the coupling stage on, ten with it off) go through one
// 19x24 multiplier and one 46-bit accumulator. Each biquad steps through five products,
// a drain of the product register and a capture of the rounded result; with bypass
// the sample is ready the next cycle. The block takes no new request until the
// result has been taken.
module biquad_lowpass_highpass_split (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [bqs_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [bqs_pkg::SAMPLE_W-1:0] low_out,
    output logic signed [bqs_pkg::SAMPLE_W-1:0] high_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bqs_pkg::ADDR_W-1:0]          paddr,
    input  logic [bqs_pkg::DATA_W-1:0]          pwdata,
    output logic [bqs_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    bqs_pkg::cfg_t    cfg;
    bqs_pkg::mac_op_t mac_op;
    logic signed [bqs_pkg::SAMPLE_W-1:0] mac_result;

    bqs_pkg::state_t  state_reg, state_next;
    bqs_pkg::stage_t  stage_reg, stage_next;
    bqs_pkg::tap_t    tap_reg, tap_next;

    // Per stage: x[n-1], x[n-2], y[n-1], y[n-2].
    logic signed [bqs_pkg::SAMPLE_W-1:0] hist_reg [0:2][0:3];
    logic signed [bqs_pkg::SAMPLE_W-1:0] x_reg;
    logic signed [bqs_pkg::SAMPLE_W-1:0] t_reg;
    logic signed [bqs_pkg::SAMPLE_W-1:0] low_reg;
    logic signed [bqs_pkg::SAMPLE_W-1:0] high_reg;
    logic signed [bqs_pkg::SAMPLE_W-1:0] x_stage;
    logic [1:0]                          sidx;
    logic [bqs_pkg::BPK_W-1:0]           b_word;
    logic [bqs_pkg::APK_W-1:0]           a_word;
    logic                                in_accept;
    logic                                capture;

    bqs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bqs_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (mac_op),
        .result (mac_result)
    );

    assign in_stall  = (state_reg != bqs_pkg::ST_IDLE);
    assign out_valid = (state_reg == bqs_pkg::ST_OUT);
    assign low_out   = low_reg;
    assign high_out  = high_reg;
    assign in_accept = in_valid && !in_stall;
    assign capture   = (state_reg == bqs_pkg::ST_RUN) && (tap_reg == bqs_pkg::TAP_CAPTURE);

    assign sidx    = 2'(stage_reg);
    assign b_word  = cfg.b_coefs[sidx];
    assign a_word  = cfg.a_coefs[sidx];
    assign x_stage = (stage_reg == bqs_pkg::STG_CPL) ? x_reg : t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bqs_pkg::ST_IDLE;
            stage_reg <= bqs_pkg::STG_CPL;
            tap_reg   <= bqs_pkg::TAP_B0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            tap_reg   <= tap_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        tap_next   = tap_reg;
        mac_op     = '0;
        case (state_reg)
            bqs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    tap_next = bqs_pkg::TAP_B0;
                    if (!cfg.filter_enable)
                    begin
                        state_next = bqs_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = bqs_pkg::ST_RUN;
                        stage_next = cfg.coupling_mode ? bqs_pkg::STG_CPL : bqs_pkg::STG_LP;
                    end
                end
            end
            bqs_pkg::ST_RUN:
            begin
                tap_next = bqs_pkg::tap_t'(tap_reg + 3'd1);
                case (tap_reg)
                    bqs_pkg::TAP_B0:
                    begin
                        mac_op.valid = 1'b1;
                        mac_op.first = 1'b1;
                        mac_op.coef  = bqs_pkg::coef_b(b_word, 2'd0);
                        mac_op.data  = x_stage;
                    end
                    bqs_pkg::TAP_B1:
                    begin
                        mac_op.valid = 1'b1;
                        mac_op.coef  = bqs_pkg::coef_b(b_word, 2'd1);
                        mac_op.data  = hist_reg[sidx][0];
                    end
                    bqs_pkg::TAP_B2:
                    begin
                        mac_op.valid = 1'b1;
                        mac_op.coef  = bqs_pkg::coef_b(b_word, 2'd2);
                        mac_op.data  = hist_reg[sidx][1];
                    end
                    bqs_pkg::TAP_A1:
                    begin
                        mac_op.valid = 1'b1;
                        mac_op.coef  = bqs_pkg::coef_a_neg(a_word, 1'b0);
                        mac_op.data  = hist_reg[sidx][2];
                    end
                    bqs_pkg::TAP_A2:
                    begin
                        mac_op.valid = 1'b1;
                        mac_op.coef  = bqs_pkg::coef_a_neg(a_word, 1'b1);
                        mac_op.data  = hist_reg[sidx][3];
                    end
                    bqs_pkg::TAP_DRAIN: ;
                    bqs_pkg::TAP_CAPTURE:
                    begin
                        tap_next = bqs_pkg::TAP_B0;
                        case (stage_reg)
                            bqs_pkg::STG_CPL: stage_next = bqs_pkg::STG_LP;
                            bqs_pkg::STG_LP:  stage_next = bqs_pkg::STG_HP;
                            default:          state_next = bqs_pkg::ST_OUT;
                        endcase
                    end
                    default: tap_next = bqs_pkg::TAP_B0;
                endcase
            end
            bqs_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = bqs_pkg::ST_IDLE;
                end
            end
            default: state_next = bqs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 3; s++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    hist_reg[s][k] <= '0;
                end
            end
        end
        else if (capture)
        begin
            hist_reg[sidx][1] <= hist_reg[sidx][0];
            hist_reg[sidx][0] <= x_stage;
            hist_reg[sidx][3] <= hist_reg[sidx][2];
            hist_reg[sidx][2] <= mac_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg    <= sample_in;
            t_reg    <= sample_in;
            low_reg  <= sample_in;
            high_reg <= sample_in;
        end
        else if (capture)
        begin
            case (stage_reg)
                bqs_pkg::STG_CPL: t_reg    <= mac_result;
                bqs_pkg::STG_LP:  low_reg  <= mac_result;
                default:          high_reg <= mac_result;
            endcase
        end
    end

    // No new request may be taken while a result is still on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken while result pending");

    // The multiplier is only issued while a filter pass is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_op.valid |-> (state_reg == bqs_pkg::ST_RUN))
        else $error("multiply issued outside a filter pass");

    // A bypassed sample shows up on both outputs in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !cfg.filter_enable) |=>
            (out_valid && (low_out == $past(sample_in)) && (high_out == $past(sample_in))))
        else $error("bypass result wrong");

    // History only moves during a capture step.
    assert property (@(posedge clk) disable iff (!rst_n)
        !capture |=> $stable(hist_reg[0][2]) && $stable(hist_reg[1][2])
            && $stable(hist_reg[2][2]))
        else $error("history changed outside a capture step");

endmodule

### design/bqs_regs.sv
module bqs_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bqs_pkg::ADDR_W-1:0] paddr,
    input  logic [bqs_pkg::DATA_W-1:0] pwdata,
    output logic [bqs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output bqs_pkg::cfg_t              cfg
);

    bqs_pkg::cfg_t      cfg_reg;
    bqs_pkg::reg_idx_t  idx;
    logic               wr_en;

    assign idx    = bqs_pkg::reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_enable <= 1'b0;
            cfg_reg.coupling_mode <= 1'b1;
            cfg_reg.b_coefs       <= '0;
            cfg_reg.a_coefs       <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                bqs_pkg::REG_FILTER_ENABLE: cfg_reg.filter_enable <= pwdata[0];
                bqs_pkg::REG_COUPLING_MODE: cfg_reg.coupling_mode <= pwdata[0];
                bqs_pkg::REG_CPL_B: cfg_reg.b_coefs[0] <= pwdata[bqs_pkg::BPK_W-1:0];
                bqs_pkg::REG_CPL_A: cfg_reg.a_coefs[0] <= pwdata[bqs_pkg::APK_W-1:0];
                bqs_pkg::REG_LP_B:  cfg_reg.b_coefs[1] <= pwdata[bqs_pkg::BPK_W-1:0];
                bqs_pkg::REG_LP_A:  cfg_reg.a_coefs[1] <= pwdata[bqs_pkg::APK_W-1:0];
                bqs_pkg::REG_HP_B:  cfg_reg.b_coefs[2] <= pwdata[bqs_pkg::BPK_W-1:0];
                bqs_pkg::REG_HP_A:  cfg_reg.a_coefs[2] <= pwdata[bqs_pkg::APK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            bqs_pkg::REG_FILTER_ENABLE: prdata[0] = cfg_reg.filter_enable;
            bqs_pkg::REG_COUPLING_MODE: prdata[0] = cfg_reg.coupling_mode;
            bqs_pkg::REG_CPL_B: prdata[bqs_pkg::BPK_W-1:0] = cfg_reg.b_coefs[0];
            bqs_pkg::REG_CPL_A: prdata[bqs_pkg::APK_W-1:0] = cfg_reg.a_coefs[0];
            bqs_pkg::REG_LP_B:  prdata[bqs_pkg::BPK_W-1:0] = cfg_reg.b_coefs[1];
            bqs_pkg::REG_LP_A:  prdata[bqs_pkg::APK_W-1:0] = cfg_reg.a_coefs[1];
            bqs_pkg::REG_HP_B:  prdata[bqs_pkg::BPK_W-1:0] = cfg_reg.b_coefs[2];
            bqs_pkg::REG_HP_A:  prdata[bqs_pkg::APK_W-1:0] = cfg_reg.a_coefs[2];
            default: prdata = '0;
        endcase
    end

endmodule

### design/bqs_mac.sv
module bqs_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bqs_pkg::mac_op_t                    op,
    output logic signed [bqs_pkg::SAMPLE_W-1:0] result
);

    localparam logic signed [bqs_pkg::SAMPLE_W-1:0] SMAX = {1'b0, {(bqs_pkg::SAMPLE_W-1){1'b1}}};
    localparam logic signed [bqs_pkg::SAMPLE_W-1:0] SMIN = {1'b1, {(bqs_pkg::SAMPLE_W-1){1'b0}}};
    localparam int RND_W = bqs_pkg::ACC_W + 1;
    localparam int SH_W  = RND_W - 16;

    logic signed [bqs_pkg::PROD_W-1:0] prod_reg;
    logic signed [bqs_pkg::PROD_W-1:0] prod_next;
    logic                              pvld_reg;
    logic                              pfirst_reg;
    logic signed [bqs_pkg::ACC_W-1:0]  acc_reg;
    logic signed [RND_W-1:0]           rnd;
    logic signed [SH_W-1:0]            shifted;

    assign prod_next = op.coef * op.data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg   <= 1'b0;
            pfirst_reg <= 1'b0;
        end
        else
        begin
            pvld_reg   <= op.valid;
            pfirst_reg <= op.first;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.valid)
        begin
            prod_reg <= prod_next;
        end
        if (pvld_reg)
        begin
            if (pfirst_reg)
            begin
                acc_reg <= bqs_pkg::ACC_W'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + bqs_pkg::ACC_W'(prod_reg);
            end
        end
    end

    // Round half up from Q.39 to Q1.23, then clip to the sample range.
    assign rnd     = RND_W'(acc_reg) + RND_W'(32768);
    assign shifted = SH_W'(rnd >>> 16);

    always_comb
    begin
        if (shifted > SH_W'(SMAX))
        begin
            result = SMAX;
        end
        else if (shifted < SH_W'(SMIN))
        begin
            result = SMIN;
        end
        else
        begin
            result = bqs_pkg::SAMPLE_W'(shifted);
        end
    end

endmodule

### dv/crossover_monitor.sv
`timescale 1ns / 1ps
module crossover_monitor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [bqs_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [bqs_pkg::SAMPLE_W-1:0] low_out,
    input  logic signed [bqs_pkg::SAMPLE_W-1:0] high_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [bqs_pkg::ADDR_W-1:0]          paddr,
    input  logic [bqs_pkg::DATA_W-1:0]          pwdata,
    output int                                  outstanding,
    output int                                  mismatches,
    output int                                  checked
);

    typedef struct packed {
        logic signed [bqs_pkg::SAMPLE_W-1:0] low;
        logic signed [bqs_pkg::SAMPLE_W-1:0] high;
    } split_pair_t;

    localparam longint SAT_MAX = 64'sd8388607;
    localparam longint SAT_MIN = -64'sd8388608;

    logic                                enable_q;
    logic                                coupling_q;
    logic [bqs_pkg::BPK_W-1:0]           b_q [3];
    logic [bqs_pkg::APK_W-1:0]           a_q [3];
    // Per stage: x[n-1], x[n-2], y[n-1], y[n-2].
    logic signed [bqs_pkg::SAMPLE_W-1:0] hist [3][4];
    split_pair_t                         split_q[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0d, expected %0d (result %0d)", $realtime, what, got, want,
                 checked);
        mismatches++;
    endtask

    // One direct form I step: exact accumulation, round half up, saturate.
    function automatic logic signed [bqs_pkg::SAMPLE_W-1:0] run_stage(
        input bqs_pkg::stage_t                     s,
        input logic signed [bqs_pkg::SAMPLE_W-1:0] x
    );
        longint                              c [5];
        longint                              acc;
        longint                              rounded;
        logic signed [bqs_pkg::SAMPLE_W-1:0] y;
        for (int k = 0; k < 3; k++)
        begin
            c[k] = $signed(b_q[s][bqs_pkg::COEF_W*k +: bqs_pkg::COEF_W]);
        end
        for (int k = 0; k < 2; k++)
        begin
            c[3+k] = $signed(a_q[s][bqs_pkg::COEF_W*k +: bqs_pkg::COEF_W]);
        end
        acc = c[0] * x + c[1] * hist[s][0] + c[2] * hist[s][1]
            - c[3] * hist[s][2] - c[4] * hist[s][3];
        rounded = (acc + 64'sd32768) >>> 16;
        if (rounded > SAT_MAX)
        begin
            y = bqs_pkg::SAMPLE_W'(SAT_MAX);
        end
        else if (rounded < SAT_MIN)
        begin
            y = bqs_pkg::SAMPLE_W'(SAT_MIN);
        end
        else
        begin
            y = bqs_pkg::SAMPLE_W'(rounded);
        end
        hist[s][1] = hist[s][0];
        hist[s][0] = x;
        hist[s][3] = hist[s][2];
        hist[s][2] = y;
        return y;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        split_pair_t                         want;
        logic signed [bqs_pkg::SAMPLE_W-1:0] feed;
        if (!rst_n)
        begin
            enable_q   = 1'b0;
            coupling_q = 1'b1;
            for (int s = 0; s < 3; s++)
            begin
                b_q[s] = '0;
                a_q[s] = '0;
                for (int k = 0; k < 4; k++)
                begin
                    hist[s][k] = '0;
                end
            end
            split_q.delete();
            mismatches = 0;
            checked    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (bqs_pkg::reg_idx_t'(paddr[5:3]))
                    bqs_pkg::REG_FILTER_ENABLE: enable_q   = pwdata[0];
                    bqs_pkg::REG_COUPLING_MODE: coupling_q = pwdata[0];
                    bqs_pkg::REG_CPL_B: b_q[bqs_pkg::STG_CPL] = pwdata[bqs_pkg::BPK_W-1:0];
                    bqs_pkg::REG_CPL_A: a_q[bqs_pkg::STG_CPL] = pwdata[bqs_pkg::APK_W-1:0];
                    bqs_pkg::REG_LP_B:  b_q[bqs_pkg::STG_LP]  = pwdata[bqs_pkg::BPK_W-1:0];
                    bqs_pkg::REG_LP_A:  a_q[bqs_pkg::STG_LP]  = pwdata[bqs_pkg::APK_W-1:0];
                    bqs_pkg::REG_HP_B:  b_q[bqs_pkg::STG_HP]  = pwdata[bqs_pkg::BPK_W-1:0];
                    bqs_pkg::REG_HP_A:  a_q[bqs_pkg::STG_HP]  = pwdata[bqs_pkg::APK_W-1:0];
                    default: ;
                endcase
            end
            // A result taken in the same cycle as a request belongs to an older one.
            if (out_valid && !out_stall)
            begin
                if (split_q.size() == 0)
                begin
                    report_mismatch("unexpected result, low_out", low_out, 0);
                end
                else
                begin
                    want = split_q.pop_front();
                    if (low_out !== want.low)
                    begin
                        report_mismatch("low_out", low_out, want.low);
                    end
                    if (high_out !== want.high)
                    begin
                        report_mismatch("high_out", high_out, want.high);
                    end
                end
                checked++;
            end
            if (in_valid && !in_stall)
            begin
                if (!enable_q)
                begin
                    want.low  = sample_in;
                    want.high = sample_in;
                end
                else
                begin
                    feed      = coupling_q ? run_stage(bqs_pkg::STG_CPL, sample_in)
                                           : sample_in;
                    want.low  = run_stage(bqs_pkg::STG_LP, feed);
                    want.high = run_stage(bqs_pkg::STG_HP, feed);
                end
                split_q.push_back(want);
            end
        end
        outstanding = split_q.size();
    end

endmodule

### dv/tb_biquad_lowpass_highpass_split.sv
`timescale 1ns / 1ps
module tb_biquad_lowpass_highpass_split;

    localparam int HOLD_CYCLES     = 400;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 30;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int HOLD_PHASE      = 3;

    typedef enum int {
        COEF_AUDIO  = 0,
        COEF_RANDOM = 1,
        COEF_MAX    = 2,
        COEF_MIN    = 3,
        COEF_SMALL  = 4
    } coef_style_t;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic signed [bqs_pkg::SAMPLE_W-1:0] sample_in;
    logic                                out_valid;
    logic                                out_stall;
    logic signed [bqs_pkg::SAMPLE_W-1:0] low_out;
    logic signed [bqs_pkg::SAMPLE_W-1:0] high_out;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [bqs_pkg::ADDR_W-1:0]          paddr;
    logic [bqs_pkg::DATA_W-1:0]          pwdata;
    logic [bqs_pkg::DATA_W-1:0]          prdata;
    logic                                pready;

    int outstanding;
    int mismatches;
    int checked;
    int items_sent    = 0;
    int settings_used = 0;
    int holds_asked   = 0;
    int holds_done    = 0;
    int idle_cycles   = 0;
    bit gaps_on       = 1'b1;

    biquad_lowpass_highpass_split dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample_in (sample_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .low_out   (low_out),
        .high_out  (high_out),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    crossover_monitor monitor_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .low_out     (low_out),
        .high_out    (high_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .outstanding (outstanding),
        .mismatches  (mismatches),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Output side: random stall before each result, plus the long hold on request.
    initial
    begin
        int gap;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (holds_asked > holds_done)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            gap = gaps_on ? $urandom_range(0, 10) : 0;
            if (gap != 0)
            begin
                out_stall = 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall = 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic reg_write(input bqs_pkg::reg_idx_t idx,
                             input logic [bqs_pkg::DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Leaves the request raised so that back-to-back samples need no drop.
    task automatic send_sample(input logic signed [bqs_pkg::SAMPLE_W-1:0] value);
        int gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        sample_in = value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic quiesce();
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [bqs_pkg::DATA_W-1:0] pack_b(input int b0, input int b1,
                                                          input int b2);
        return bqs_pkg::DATA_W'({bqs_pkg::COEF_W'(b2), bqs_pkg::COEF_W'(b1),
                                 bqs_pkg::COEF_W'(b0)});
    endfunction

    function automatic logic [bqs_pkg::DATA_W-1:0] pack_a(input int a1, input int a2);
        return bqs_pkg::DATA_W'({bqs_pkg::COEF_W'(a2), bqs_pkg::COEF_W'(a1)});
    endfunction

    function automatic int pick_coef(input coef_style_t style);
        case (style)
            COEF_MAX: return 131071;
            COEF_MIN: return -131072;
            default:  return int'($urandom_range(0, 8192)) - 4096;
        endcase
    endfunction

    task automatic load_coefs(input coef_style_t style);
        logic [bqs_pkg::DATA_W-1:0] w [6];
        if (style == COEF_AUDIO)
        begin
            // DC blocker ahead of a low, narrow-band lowpass and highpass pair.
            w[0] = pack_b(65536, -65536, 0);
            w[1] = pack_a(-64880, 0);
            w[2] = pack_b(256, 512, 256);
            w[3] = pack_a(-124518, 59310);
            w[4] = pack_b(62000, -124000, 62000);
            w[5] = pack_a(-124518, 59310);
        end
        else if (style == COEF_RANDOM)
        begin
            // Full 64-bit words: bits above each register's width must be dropped.
            for (int k = 0; k < 6; k++)
            begin
                w[k] = {$urandom(), $urandom()};
            end
        end
        else
        begin
            for (int k = 0; k < 6; k += 2)
            begin
                w[k]   = pack_b(pick_coef(style), pick_coef(style), pick_coef(style));
                w[k+1] = pack_a(pick_coef(style), pick_coef(style));
            end
        end
        reg_write(bqs_pkg::REG_CPL_B, w[0]);
        reg_write(bqs_pkg::REG_CPL_A, w[1]);
        reg_write(bqs_pkg::REG_LP_B, w[2]);
        reg_write(bqs_pkg::REG_LP_A, w[3]);
        reg_write(bqs_pkg::REG_HP_B, w[4]);
        reg_write(bqs_pkg::REG_HP_A, w[5]);
    endtask

    function automatic logic signed [bqs_pkg::SAMPLE_W-1:0] pick_sample();
        int t;
        case ($urandom_range(0, 9))
            0:
            begin
                return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            end
            1, 2:
            begin
                t = int'($urandom_range(0, 4000)) - 2000;
                return bqs_pkg::SAMPLE_W'(t);
            end
            default:
            begin
                return bqs_pkg::SAMPLE_W'($urandom());
            end
        endcase
    endfunction

    initial
    begin
        logic [bqs_pkg::DATA_W-1:0] mode_word;
        coef_style_t                style;
        in_valid  = 1'b0;
        sample_in = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        rst_n     = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset state is bypass: both outputs copy the input.
        settings_used++;
        send_sample(24'sd0);
        send_sample(24'sh7fffff);
        send_sample(24'sh800000);
        send_sample(-24'sd1);
        send_sample(24'sd1);

        // Extreme coefficients drive both branches into saturation.
        quiesce();
        reg_write(bqs_pkg::REG_FILTER_ENABLE, 64'd1);
        reg_write(bqs_pkg::REG_COUPLING_MODE, 64'd1);
        reg_write(bqs_pkg::REG_CPL_B, pack_b(65536, 0, 0));
        reg_write(bqs_pkg::REG_CPL_A, pack_a(0, 0));
        reg_write(bqs_pkg::REG_LP_B, pack_b(131071, 131071, 131071));
        reg_write(bqs_pkg::REG_LP_A, pack_a(-131072, -131072));
        reg_write(bqs_pkg::REG_HP_B, pack_b(-131072, -131072, -131072));
        reg_write(bqs_pkg::REG_HP_A, pack_a(131071, 131071));
        settings_used++;
        send_sample(24'sh7fffff);
        send_sample(24'sh7fffff);
        send_sample(24'sh800000);
        send_sample(24'sh800000);
        send_sample(24'sd0);
        send_sample(24'sd1);
        send_sample(-24'sd1);

        // Coupling off: raw sample feeds both branches, coupling history frozen.
        quiesce();
        reg_write(bqs_pkg::REG_COUPLING_MODE, 64'd0);
        settings_used++;
        send_sample(24'sh7fffff);
        send_sample(24'sh800000);
        send_sample(24'sd12345);
        send_sample(-24'sd12345);

        // Bypass in the middle must hold history for when filtering resumes.
        quiesce();
        reg_write(bqs_pkg::REG_FILTER_ENABLE, 64'd0);
        settings_used++;
        send_sample(24'sd100);
        send_sample(-24'sd100);
        send_sample(24'sd7);
        quiesce();
        reg_write(bqs_pkg::REG_FILTER_ENABLE, 64'd1);
        reg_write(bqs_pkg::REG_COUPLING_MODE, 64'd1);
        load_coefs(COEF_AUDIO);
        settings_used++;
        send_sample(24'sd4000000);
        send_sample(-24'sd4000000);
        send_sample(24'sd0);
        send_sample(24'sh7fffff);
        send_sample(24'sh800000);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            quiesce();
            mode_word    = {$urandom(), $urandom()};
            mode_word[0] = ($urandom_range(0, 4) != 0);
            reg_write(bqs_pkg::REG_FILTER_ENABLE, mode_word);
            reg_write(bqs_pkg::REG_COUPLING_MODE, {$urandom(), $urandom()});
            style = (phase == 0) ? COEF_AUDIO : coef_style_t'($urandom_range(0, 4));
            load_coefs(style);
            settings_used++;
            gaps_on = (phase == HOLD_PHASE) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (phase == HOLD_PHASE && i == 40)
                begin
                    holds_asked++;
                end
                send_sample(pick_sample());
            end
            gaps_on = 1'b1;
        end

        quiesce();
        $display("Ran %0d samples across %0d register settings, covering bypass, coupling on",
                 items_sent, settings_used);
        $display("and off, saturating coefficients and a %0d-cycle output hold; %0d results.",
                 HOLD_CYCLES, checked);
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
